[rtl/core/hrhp_pkg.sv]
package hrhp_pkg;

  localparam int HEADER_LIMIT = 2048;
  localparam int MAX_LINES    = 10;
  localparam int KEY_LEN      = 14;

  localparam int CNT_W  = $clog2(HEADER_LIMIT + 1);
  localparam int LINE_W = $clog2(MAX_LINES + 1);
  localparam int POS_W  = $clog2(KEY_LEN + 1);

  localparam logic [0:KEY_LEN-1][7:0] KEY_TEXT = "Content-Length";

  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam logic [7:0]  CH_COLON   = 8'h3A;
  localparam logic [7:0]  CH_LF      = 8'h0A;
  localparam logic [31:0] END_MARK   = 32'h0D0A0D0A;
  localparam logic [15:0] STATUS_NONE = 16'd400;
  localparam logic [15:0] STATUS_SAT  = 16'hFFFF;
  localparam logic [47:0] LEN_ALL_ONES = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] LIMIT_RESET  = 32'd1048576;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_STATUS = 2'd1;
  localparam logic [1:0] ERR_LIMIT  = 2'd2;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic               is_digit;
    logic               is_space;
    logic               is_blank;
    logic               is_colon;
    logic               is_lf;
    logic               is_zero;
    logic [KEY_LEN-1:0] key_hit;
  } item_t;

  typedef struct packed {
    logic [15:0] status_code;
    logic        header_ok;
    logic [1:0]  error_code;
    logic        length_found;
    logic [47:0] content_length;
    logic [31:0] transfer_length;
    logic [11:0] header_length;
  } result_t;

endpackage

[rtl/core/hrhp_ifs.sv]
interface hrhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface hrhp_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] download_limit;
  modport source (output valid, output download_limit, input ready);
  modport sink (input valid, input download_limit, output ready);
endinterface

interface hrhp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] status_code;
  logic        header_ok;
  logic [1:0]  error_code;
  logic        length_found;
  logic [47:0] content_length;
  logic [31:0] transfer_length;
  logic [11:0] header_length;
  modport source (output valid, output status_code, output header_ok, output error_code,
                  output length_found, output content_length, output transfer_length,
                  output header_length, input ready);
  modport sink (input valid, input status_code, input header_ok, input error_code,
                input length_found, input content_length, input transfer_length,
                input header_length, output ready);
endinterface

[rtl/core/http_response_header_parser.sv]
// HTTP response header parser.
// data_in carries one header byte per item; valid/ready, taken when both are high.
// result_out carries one item per header: status, 2xx flag, error code, whether a
// Content-Length line was seen, the length, the length clipped to download_limit,
// and the header byte count. A result follows the byte that completes CR LF CR LF
// or the byte that brings the count to the header size limit (2048 bytes).
// cfg writes download_limit; it is always ready and should be written while idle.
// Throughput: one byte per cycle via the back end parse step, while no result stalls.
// A classifier stage and a two-entry queue sit ahead of the parser, and a result
// register sits behind it, so the queue and classifier can still take bytes while a result waits to be taken.
// When result_out stalls with a result held, the parser stops and the queue and
// classifier fill, after which data_in.ready drops.
// Reset (rst, synchronous) empties all stages, clears the parse state and sets
// download_limit to 1048576.
module http_response_header_parser (
  input logic        clk,
  input logic        rst,
  hrhp_in_if.sink    data_in,
  hrhp_cfg_if.sink   cfg,
  hrhp_out_if.source result_out
);

  logic              f_valid;
  logic              f_ready;
  hrhp_pkg::item_t   f_item;
  logic              q_valid;
  logic              q_ready;
  hrhp_pkg::item_t   q_item;
  hrhp_pkg::result_t res;

  assign cfg.ready = 1'b1;

  hrhp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (data_in.valid),
    .in_ready   (data_in.ready),
    .in_byte    (data_in.data_byte),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  hrhp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  hrhp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg.valid),
    .cfg_data   (cfg.download_limit),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .res_valid  (result_out.valid),
    .res_ready  (result_out.ready),
    .res        (res)
  );

  assign result_out.status_code     = res.status_code;
  assign result_out.header_ok       = res.header_ok;
  assign result_out.error_code      = res.error_code;
  assign result_out.length_found    = res.length_found;
  assign result_out.content_length  = res.content_length;
  assign result_out.transfer_length = res.transfer_length;
  assign result_out.header_length   = res.header_length;

endmodule

[rtl/core/hrhp_front.sv]
module hrhp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  output logic            item_valid,
  input  logic            item_ready,
  output hrhp_pkg::item_t item
);

  hrhp_pkg::item_t cls;
  logic            stage_valid;
  hrhp_pkg::item_t stage;

  always_comb begin
    cls.data_byte = in_byte;
    cls.is_digit  = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    cls.is_blank  = (in_byte == hrhp_pkg::CH_SPACE);
    cls.is_space  = (in_byte == hrhp_pkg::CH_SPACE) ||
                    ((in_byte >= 8'h09) && (in_byte <= 8'h0D));
    cls.is_colon  = (in_byte == hrhp_pkg::CH_COLON);
    cls.is_lf     = (in_byte == hrhp_pkg::CH_LF);
    cls.is_zero   = (in_byte == 8'h00);
    for (int i = 0; i < hrhp_pkg::KEY_LEN; i++) begin
      cls.key_hit[i] = (in_byte == hrhp_pkg::KEY_TEXT[i]);
    end
  end

  assign in_ready   = !stage_valid || item_ready;
  assign item_valid = stage_valid;
  assign item       = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage <= cls;
    end
  end

endmodule

[rtl/core/hrhp_queue.sv]
module hrhp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  hrhp_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output hrhp_pkg::item_t pop_item
);

  hrhp_pkg::item_t mem [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;
  logic            pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule

[rtl/core/hrhp_back.sv]
module hrhp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [31:0]       cfg_data,
  input  logic              item_valid,
  output logic              item_ready,
  input  hrhp_pkg::item_t   item,
  output logic              res_valid,
  input  logic              res_ready,
  output hrhp_pkg::result_t res
);

  typedef enum logic [3:0] {
    ST_SEEK   = 4'b0001,
    ST_SKIP   = 4'b0010,
    ST_DIGITS = 4'b0100,
    ST_DONE   = 4'b1000
  } status_phase_t;

  typedef enum logic [3:0] {
    LN_IDLE   = 4'b0001,
    LN_COLON  = 4'b0010,
    LN_SKIP   = 4'b0100,
    LN_DIGITS = 4'b1000
  } length_phase_t;

  logic [31:0]                   download_limit;
  logic [hrhp_pkg::CNT_W-1:0]    byte_total, byte_total_next;
  logic [23:0]                   recent_bytes;
  logic [hrhp_pkg::LINE_W-1:0]   line_number, line_number_next;
  logic                          line_start, line_start_next;
  logic [hrhp_pkg::POS_W-1:0]    match_pos, match_pos_next;
  status_phase_t                 status_phase, status_phase_next;
  logic [15:0]                   status_value, status_value_next;
  length_phase_t                 length_phase, length_phase_next;
  logic [47:0]                   length_value, length_value_next;
  logic                          length_seen, length_seen_next;
  logic                          text_ended, text_ended_next;

  logic                          pop;
  logic [31:0]                   window;
  logic                          hit_limit;
  logic                          hit_end;
  logic [3:0]                    digit;
  logic [19:0]                   status_acc;
  logic [51:0]                   length_acc;
  logic                          status_good;
  logic [31:0]                   clip;
  hrhp_pkg::result_t             res_next;

  assign item_ready = !res_valid || res_ready;
  assign pop        = item_valid && item_ready;
  assign window     = {recent_bytes, item.data_byte};
  assign digit      = item.data_byte[3:0];
  assign status_acc = {1'b0, status_value, 3'b000} + {3'b000, status_value, 1'b0}
                    + {16'd0, digit};
  assign length_acc = {1'b0, length_value, 3'b000} + {3'b000, length_value, 1'b0}
                    + {48'd0, digit};

  always_comb begin
    byte_total_next   = byte_total + 1'b1;
    line_number_next  = line_number;
    line_start_next   = line_start;
    match_pos_next    = match_pos;
    status_phase_next = status_phase;
    status_value_next = status_value;
    length_phase_next = length_phase;
    length_value_next = length_value;
    length_seen_next  = length_seen;
    text_ended_next   = text_ended;

    if (!text_ended) begin
      if (item.is_zero) begin
        text_ended_next = 1'b1;
      end else begin
        unique case (status_phase)
          ST_SEEK: begin
            if (item.is_blank) status_phase_next = ST_SKIP;
          end
          ST_SKIP: begin
            if (item.is_digit) begin
              status_value_next = {12'd0, digit};
              status_phase_next = ST_DIGITS;
            end else if (!item.is_space) begin
              status_phase_next = ST_DONE;
            end
          end
          ST_DIGITS: begin
            if (item.is_digit) begin
              status_value_next = (status_acc[19:16] != 4'd0) ? hrhp_pkg::STATUS_SAT
                                                               : status_acc[15:0];
            end else begin
              status_phase_next = ST_DONE;
            end
          end
          ST_DONE: ;
          default: ;
        endcase

        unique case (length_phase)
          LN_IDLE: ;
          LN_COLON: begin
            if (item.is_colon) length_phase_next = LN_SKIP;
          end
          LN_SKIP: begin
            if (item.is_digit) begin
              length_value_next = {44'd0, digit};
              length_phase_next = LN_DIGITS;
            end else if (!item.is_space) begin
              length_phase_next = LN_IDLE;
            end
          end
          LN_DIGITS: begin
            if (item.is_digit) begin
              length_value_next = (length_acc[51:48] != 4'd0) ? hrhp_pkg::LEN_ALL_ONES
                                                               : length_acc[47:0];
            end else begin
              length_phase_next = LN_IDLE;
            end
          end
          default: ;
        endcase

        if (line_start) begin
          line_start_next = 1'b0;
          if (line_number < hrhp_pkg::LINE_W'(hrhp_pkg::MAX_LINES)) begin
            line_number_next = line_number + 1'b1;
            match_pos_next   = item.key_hit[0] ? hrhp_pkg::POS_W'(1) : '0;
          end else begin
            match_pos_next = '0;
          end
        end else if ((match_pos != '0) &&
                     (match_pos < hrhp_pkg::POS_W'(hrhp_pkg::KEY_LEN))) begin
          match_pos_next = item.key_hit[match_pos] ? match_pos + 1'b1 : '0;
        end

        if (match_pos_next >= hrhp_pkg::POS_W'(hrhp_pkg::KEY_LEN)) begin
          match_pos_next    = '0;
          length_seen_next  = 1'b1;
          length_value_next = '0;
          length_phase_next = LN_COLON;
        end

        if (item.is_lf) line_start_next = 1'b1;
      end
    end
  end

  assign hit_limit   = (byte_total_next >= hrhp_pkg::CNT_W'(hrhp_pkg::HEADER_LIMIT));
  assign hit_end     = (byte_total_next > hrhp_pkg::CNT_W'(4)) && (window == hrhp_pkg::END_MARK);
  assign status_good = (status_value >= 16'd200) && (status_value < 16'd300);
  assign clip        = (length_value > {16'd0, download_limit}) ? download_limit
                                                                 : length_value[31:0];

  always_comb begin
    if (hit_limit) begin
      res_next.status_code     = hrhp_pkg::STATUS_NONE;
      res_next.header_ok       = 1'b0;
      res_next.error_code      = hrhp_pkg::ERR_LIMIT;
      res_next.length_found    = 1'b0;
      res_next.content_length  = hrhp_pkg::LEN_ALL_ONES;
      res_next.transfer_length = '0;
    end else begin
      res_next.status_code     = status_value;
      res_next.header_ok       = status_good;
      res_next.error_code      = status_good ? hrhp_pkg::ERR_NONE : hrhp_pkg::ERR_STATUS;
      res_next.length_found    = length_seen;
      res_next.content_length  = length_value;
      res_next.transfer_length = clip;
    end
    res_next.header_length = 12'(byte_total_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      download_limit <= hrhp_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      download_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (pop && (hit_limit || hit_end))) begin
      byte_total   <= '0;
      recent_bytes <= '0;
      line_number  <= '0;
      line_start   <= 1'b1;
      match_pos    <= '0;
      status_phase <= ST_SEEK;
      status_value <= hrhp_pkg::STATUS_NONE;
      length_phase <= LN_IDLE;
      length_value <= hrhp_pkg::LEN_ALL_ONES;
      length_seen  <= 1'b0;
      text_ended   <= 1'b0;
    end else if (pop) begin
      byte_total   <= byte_total_next;
      recent_bytes <= window[23:0];
      line_number  <= line_number_next;
      line_start   <= line_start_next;
      match_pos    <= match_pos_next;
      status_phase <= status_phase_next;
      status_value <= status_value_next;
      length_phase <= length_phase_next;
      length_value <= length_value_next;
      length_seen  <= length_seen_next;
      text_ended   <= text_ended_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop && (hit_limit || hit_end)) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (hit_limit || hit_end)) begin
      res <= res_next;
    end
  end

endmodule

[sim/tb_http_response_header_parser.sv]
`timescale 1ns / 100ps

module tb_http_response_header_parser;
  import hrhp_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RESULT_LATENCY = 2;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam string CRLF = "\015\012";

  typedef enum bit [1:0] {ST_SEEK, ST_BLANK, ST_DIGITS, ST_DONE} status_phase_e;
  typedef enum bit [1:0] {LN_IDLE, LN_COLON, LN_BLANK, LN_DIGITS} length_phase_e;
  typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  typedef struct {
    bit          is_cfg;
    logic [31:0] limit;
    string       text;
    int          nul_pos;
    int          pad;
    string       tail;
    bit          typed;
    result_t     res;
  } dir_row_t;

  logic clk;
  logic rst;

  hrhp_in_if  in_ch();
  hrhp_cfg_if cfg_ch();
  hrhp_out_if res_ch();

  http_response_header_parser uut (
    .clk(clk),
    .rst(rst),
    .data_in(in_ch),
    .cfg(cfg_ch),
    .result_out(res_ch)
  );

  // header parse state
  logic [31:0]   limit_reg;
  bit [11:0]     seen_count;
  bit [23:0]     last3;
  bit [3:0]      line_no;
  bit            line_head;
  bit [3:0]      key_pos;
  status_phase_e stat_ph;
  bit [15:0]     stat_val;
  length_phase_e len_ph;
  bit [47:0]     len_val;
  bit            len_hit;
  bit            halted;

  result_t    header_results[$];
  bit [7:0]   wire_bytes[$];
  dir_row_t   plan[$];
  int         mismatches = 0;
  int         burst_left = 5;
  int         idle_cycles = 0;
  rx_mode_e   rx_mode = RX_OPEN;
  int         rx_left = 0;
  int         rx_tick = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic bit is_num(bit [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_blank(bit [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  task automatic clear_parse();
    seen_count = '0;
    last3 = '0;
    line_no = '0;
    line_head = 1'b1;
    key_pos = '0;
    stat_ph = ST_SEEK;
    stat_val = STATUS_NONE;
    len_ph = LN_IDLE;
    len_val = LEN_ALL_ONES;
    len_hit = 1'b0;
    halted = 1'b0;
  endtask

  task automatic parse_char(input bit [7:0] b);
    longint unsigned acc;
    bit [7:0] d;
    d = b - "0";
    case (stat_ph)
      ST_SEEK: if (b == CH_SPACE) stat_ph = ST_BLANK;
      ST_BLANK: begin
        if (is_num(b)) begin
          stat_val = 16'(d);
          stat_ph = ST_DIGITS;
        end else if (!is_blank(b)) begin
          stat_ph = ST_DONE;
        end
      end
      ST_DIGITS: begin
        if (is_num(b)) begin
          acc = 64'(stat_val) * 10 + 64'(d);
          stat_val = (acc > 64'(STATUS_SAT)) ? STATUS_SAT : acc[15:0];
        end else begin
          stat_ph = ST_DONE;
        end
      end
      default: ;
    endcase
    case (len_ph)
      LN_COLON: if (b == CH_COLON) len_ph = LN_BLANK;
      LN_BLANK: begin
        if (is_num(b)) begin
          len_val = 48'(d);
          len_ph = LN_DIGITS;
        end else if (!is_blank(b)) begin
          len_ph = LN_IDLE;
        end
      end
      LN_DIGITS: begin
        if (is_num(b)) begin
          acc = 64'(len_val) * 10 + 64'(d);
          len_val = (acc > 64'(LEN_ALL_ONES)) ? LEN_ALL_ONES : acc[47:0];
        end else begin
          len_ph = LN_IDLE;
        end
      end
      default: ;
    endcase
    if (line_head) begin
      line_head = 1'b0;
      if (line_no < MAX_LINES) begin
        line_no++;
        key_pos = (b == KEY_TEXT[0]) ? 4'd1 : 4'd0;
      end else begin
        key_pos = '0;
      end
    end else if (key_pos > 0 && key_pos < KEY_LEN) begin
      if (b == KEY_TEXT[key_pos]) key_pos++;
      else key_pos = '0;
    end
    if (key_pos >= KEY_LEN) begin
      key_pos = '0;
      len_hit = 1'b1;
      len_val = '0;
      len_ph = LN_COLON;
    end
    if (b == CH_LF) line_head = 1'b1;
  endtask

  task automatic consume_byte(input bit [7:0] b, output bit done, output result_t r);
    bit [31:0] window;
    bit        ok;
    done = 1'b0;
    r = '0;
    seen_count++;
    if (!halted) begin
      if (b == CH_NUL) halted = 1'b1;
      else parse_char(b);
    end
    window = {last3, b};
    last3 = window[23:0];
    if (seen_count >= HEADER_LIMIT) begin
      r.status_code = STATUS_NONE;
      r.error_code = ERR_LIMIT;
      r.content_length = LEN_ALL_ONES;
      r.header_length = seen_count;
      done = 1'b1;
    end else if (seen_count > 4 && window == END_MARK) begin
      ok = stat_val >= 16'd200 && stat_val < 16'd300;
      r.status_code = stat_val;
      r.header_ok = ok;
      r.error_code = ok ? ERR_NONE : ERR_STATUS;
      r.length_found = len_hit;
      r.content_length = len_val;
      r.transfer_length = (len_val > 48'(limit_reg)) ? limit_reg : len_val[31:0];
      r.header_length = seen_count;
      done = 1'b1;
    end
    if (done) clear_parse();
  endtask

  // called at a falling edge; returns at a falling edge
  task automatic send_byte(input bit [7:0] b, input bit use_given = 1'b0,
                           input result_t given = '0);
    bit      done;
    result_t r;
    in_ch.valid = 1'b1;
    in_ch.data_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    consume_byte(b, done, r);
    if (use_given) header_results.push_back(given);
    else if (done) header_results.push_back(r);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4))
        @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
  endtask

  // finish the header in progress so the parser sits at a boundary
  task automatic close_header();
    int k;
    k = 0;
    while (seen_count != 0) begin
      send_byte(END_MARK[31 - 8 * k -: 8]);
      k = (k + 1) % 4;
    end
  endtask

  task automatic wait_results_clear();
    in_ch.valid = 1'b0;
    while (header_results.size() != 0) @(negedge clk);
    repeat (RESULT_LATENCY + 2) @(negedge clk);
  endtask

  task automatic set_limit(input logic [31:0] v);
    cfg_ch.valid = 1'b1;
    cfg_ch.download_limit = v;
    do @(posedge clk); while (!cfg_ch.ready);
    limit_reg = v;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic add_text(input string s);
    foreach (s[k]) wire_bytes.push_back(s[k]);
  endtask

  task automatic add_digits(input int n);
    repeat (n) wire_bytes.push_back(8'($urandom_range("0", "9")));
  endtask

  task automatic add_blank();
    bit [7:0] pool[4] = '{" ", "\t", "\v", "\f"};
    repeat ($urandom_range(0, 2)) wire_bytes.push_back(pool[$urandom_range(0, 3)]);
  endtask

  task automatic add_eol();
    if ($urandom_range(0, 19) == 0) wire_bytes.push_back(CH_LF);
    else add_text(CRLF);
  endtask

  function automatic string filler_lines(int n);
    string s;
    s = "";
    repeat (n) s = {s, "A: 1", CRLF};
    return s;
  endfunction

  function automatic dir_row_t text_row(string s, int nul_pos = -1, int pad = 0,
                                        string tail = "");
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.limit = '0;
    row.text = s;
    row.nul_pos = nul_pos;
    row.pad = pad;
    row.tail = tail;
    row.typed = 1'b0;
    row.res = '0;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [31:0] v);
    dir_row_t row;
    row = text_row("");
    row.is_cfg = 1'b1;
    row.limit = v;
    return row;
  endfunction

  function automatic dir_row_t with_result(dir_row_t row, logic [15:0] st, logic [1:0] err,
                                           logic found, logic [47:0] len,
                                           logic [31:0] xfer);
    row.typed = 1'b1;
    row.res.status_code = st;
    row.res.header_ok = (err == ERR_NONE);
    row.res.error_code = err;
    row.res.length_found = found;
    row.res.content_length = len;
    row.res.transfer_length = xfer;
    return row;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(50, 300);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:   res_ch.ready = 1'b1;
      RX_MOSTLY: res_ch.ready = ($urandom_range(0, 3) != 0);
      RX_SPARSE: res_ch.ready = ($urandom_range(0, 3) == 0);
      default:   res_ch.ready = (rx_tick % 24) < 17;
    endcase
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (header_results.size() == 0) begin
        $error("result with no header pending: status %0d length %0d",
               res_ch.status_code, res_ch.header_length);
        mismatches++;
      end else begin
        want = header_results.pop_front();
        check_field("status_code", 64'(want.status_code), 64'(res_ch.status_code));
        check_field("header_ok", 64'(want.header_ok), 64'(res_ch.header_ok));
        check_field("error_code", 64'(want.error_code), 64'(res_ch.error_code));
        check_field("length_found", 64'(want.length_found), 64'(res_ch.length_found));
        check_field("content_length", 64'(want.content_length), 64'(res_ch.content_length));
        check_field("transfer_length", 64'(want.transfer_length),
                    64'(res_ch.transfer_length));
        check_field("header_length", 64'(want.header_length), 64'(res_ch.header_length));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_http_response_header_parser: FAIL");
      $finish;
    end
  end

  initial begin
    result_t given;
    string   key;
    int      pick;
    int      rand_bytes;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.download_limit = '0;
    limit_reg = LIMIT_RESET;
    clear_parse();

    plan.push_back(with_result(text_row({"HTTP/1.1 200 OK", CRLF, "Content-Length: 42", CRLF,
                                         CRLF}), 16'd200, ERR_NONE, 1'b1, 48'd42, 32'd42));
    plan.push_back(with_result(text_row({"HTTP/1.1 404 Not Found", CRLF, CRLF}), 16'd404,
                               ERR_STATUS, 1'b0, LEN_ALL_ONES, LIMIT_RESET));
    plan.push_back(with_result(text_row({"HTTP/1.1", CRLF, CRLF}), STATUS_NONE, ERR_STATUS,
                               1'b0, LEN_ALL_ONES, LIMIT_RESET));
    plan.push_back(with_result(text_row({"HTTP/1.1 99999999 Big", CRLF, CRLF}), STATUS_SAT,
                               ERR_STATUS, 1'b0, LEN_ALL_ONES, LIMIT_RESET));
    plan.push_back(with_result(text_row({"HTTP/1.0 299", CRLF,
                                         "Content-Length: 999999999999999999", CRLF, CRLF}),
                               16'd299, ERR_NONE, 1'b1, LEN_ALL_ONES, LIMIT_RESET));
    plan.push_back(text_row({"HTTP/1.1 201", CRLF, "Content-Length: -5", CRLF, CRLF}));
    plan.push_back(text_row({"HTTP/1.1 200 OK", CRLF, "Content-Length", CRLF, "X: 7", CRLF,
                             CRLF}));
    plan.push_back(text_row({"HTTP/1.1 200", CRLF, "Content-Length: 5", CRLF,
                             "Content-Length: 300", CRLF, CRLF}));
    plan.push_back(text_row({"HTTP/1.1 200", CRLF, "content-length: 5", CRLF,
                             "Content-Length 8", CRLF, CRLF}));
    plan.push_back(text_row({"HTTP/1.1 2#00 OK", CRLF, "Content-Length: 6", CRLF, CRLF}, 10));
    plan.push_back(text_row({"HTTP/1.1 \t\v\f 204", CRLF, "Content-Length:\t\t17 ", CRLF,
                             CRLF}));
    plan.push_back(text_row({CRLF, CRLF, "HTTP/1.1 200", CRLF, CRLF}));
    plan.push_back(text_row({"HTTP/1.1 200", CRLF, filler_lines(8), "Content-Length: 9", CRLF,
                             CRLF}));
    plan.push_back(text_row({"HTTP/1.1 200", CRLF, filler_lines(9), "Content-Length: 9", CRLF,
                             CRLF}));
    plan.push_back(text_row({"HTTP/1.1 200 \377\200", CRLF, CRLF}));
    plan.push_back(text_row({"HTTP/1.1 0", CRLF, "Content-Length: 0", CRLF, CRLF}));
    plan.push_back(cfg_row(32'd0));
    plan.push_back(with_result(text_row({"HTTP/1.1 200 OK", CRLF, "Content-Length: 42", CRLF,
                                         CRLF}), 16'd200, ERR_NONE, 1'b1, 48'd42, 32'd0));
    plan.push_back(cfg_row(32'hFFFF_FFFF));
    plan.push_back(with_result(text_row({"HTTP/1.1 200 OK", CRLF,
                                         "Content-Length: 12345678901", CRLF, CRLF}),
                               16'd200, ERR_NONE, 1'b1, 48'd12345678901, 32'hFFFF_FFFF));
    plan.push_back(with_result(text_row({"HTTP/1.1 200 OK", CRLF}, -1, HEADER_LIMIT - 17),
                               STATUS_NONE, ERR_LIMIT, 1'b0, LEN_ALL_ONES, 32'd0));
    plan.push_back(with_result(text_row({"HTTP/1.1 200 OK", CRLF}, -1, HEADER_LIMIT - 21,
                                        {CRLF, CRLF}),
                               STATUS_NONE, ERR_LIMIT, 1'b0, LEN_ALL_ONES, 32'd0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        close_header();
        wait_results_clear();
        set_limit(plan[i].limit);
      end else begin
        wire_bytes.delete();
        add_text(plan[i].text);
        if (plan[i].nul_pos >= 0) wire_bytes[plan[i].nul_pos] = CH_NUL;
        repeat (plan[i].pad) wire_bytes.push_back("x");
        add_text(plan[i].tail);
        given = plan[i].res;
        given.header_length = 12'(wire_bytes.size());
        foreach (wire_bytes[j])
          send_byte(wire_bytes[j], plan[i].typed && j == wire_bytes.size() - 1, given);
      end
    end

    rand_bytes = 0;
    while (rand_bytes < 1250) begin
      close_header();
      wait_results_clear();
      case ($urandom_range(0, 4))
        0: set_limit(32'd0);
        1: set_limit(32'hFFFF_FFFF);
        2: set_limit(LIMIT_RESET);
        3: set_limit(32'($urandom_range(0, 100)));
        default: set_limit($urandom);
      endcase
      repeat ($urandom_range(3, 10)) begin
        wire_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          repeat ($urandom_range(1, 40)) wire_bytes.push_back(8'($urandom_range(0, 255)));
          add_text({CRLF, CRLF});
        end else if (pick < 14) begin
          add_text({"HTTP/1.1 200 OK", CRLF});
          repeat ($urandom_range(2040, 2100)) wire_bytes.push_back(8'($urandom_range("a", "z")));
          add_text({CRLF, CRLF});
        end else begin
          if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 8)) wire_bytes.push_back(8'($urandom_range(33, 126)));
          end else begin
            add_text("HTTP/1.");
            add_digits(1);
          end
          if ($urandom_range(0, 19) != 0) wire_bytes.push_back(CH_SPACE);
          add_blank();
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
              wire_bytes.push_back("2");
              add_digits(2);
            end
            6, 7, 8: add_digits($urandom_range(1, 6));
            default: begin
              wire_bytes.push_back($urandom_range(0, 1) ? "+" : "-");
              add_digits($urandom_range(0, 3));
            end
          endcase
          if ($urandom_range(0, 1)) add_text(" OK");
          add_eol();
          repeat ($urandom_range(0, 12)) begin
            if ($urandom_range(0, 2) == 0) begin
              key = "Content-Length";
              if ($urandom_range(0, 9) == 0) key[$urandom_range(0, 13)] = 8'($urandom_range(33, 126));
              add_text(key);
              if ($urandom_range(0, 19) != 0) wire_bytes.push_back(CH_COLON);
              add_blank();
              if ($urandom_range(0, 19) == 0) wire_bytes.push_back($urandom_range(0, 1) ? "+" : "-");
              case ($urandom_range(0, 9))
                0: ;
                1, 2: add_digits($urandom_range(11, 20));
                default: add_digits($urandom_range(1, 10));
              endcase
              if ($urandom_range(0, 9) == 0) add_text(" x");
            end else begin
              add_text("X-");
              repeat ($urandom_range(1, 6)) wire_bytes.push_back(8'($urandom_range("a", "z")));
              add_text(": ");
              repeat ($urandom_range(0, 12)) wire_bytes.push_back(8'($urandom_range(32, 126)));
              if ($urandom_range(0, 29) == 0) wire_bytes.push_back(CH_NUL);
            end
            add_eol();
          end
          add_text(CRLF);
        end
        foreach (wire_bytes[j]) send_byte(wire_bytes[j]);
        rand_bytes += wire_bytes.size();
      end
    end

    wait_results_clear();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_http_response_header_parser: PASS");
    end else begin
      $display("tb_http_response_header_parser: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/hrhp_pkg.sv
rtl/core/hrhp_ifs.sv
rtl/core/hrhp_front.sv
rtl/core/hrhp_queue.sv
rtl/core/hrhp_back.sv
rtl/core/http_response_header_parser.sv
sim/tb_http_response_header_parser.sv
